/* rtl/bdr_pkg.sv */
`timescale 1ns / 1ps

package bdr_pkg;

    // Character width and run stack geometry
    localparam int CHAR_W    = 16;
    localparam int RUN_DEPTH = 63;
    localparam int CNT_W     = $clog2(RUN_DEPTH + 1);
    localparam int ADDR_W    = (RUN_DEPTH > 1) ? $clog2(RUN_DEPTH) : 1;

    // Classification of one character, as far as run control needs it
    typedef struct packed {
        logic ends_run;   // strong left-to-right letter or whitespace
        logic opens_run;  // Hebrew or Arabic letter
    } t_cls;

    // Bracket mirroring for characters inside a reversed run
    function automatic logic [CHAR_W-1:0] mirror(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] m;
        m = c;
        case (c)
            16'h0028: m = 16'h0029;
            16'h0029: m = 16'h0028;
            16'h003C: m = 16'h003E;
            16'h003E: m = 16'h003C;
            16'h005B: m = 16'h005D;
            16'h005D: m = 16'h005B;
            16'h007B: m = 16'h007D;
            16'h007D: m = 16'h007B;
            16'h00AB: m = 16'h00BB;
            16'h00BB: m = 16'h00AB;
            16'h2039: m = 16'h203A;
            16'h203A: m = 16'h2039;
            default:  m = c;
        endcase
        return m;
    endfunction

endpackage

/* rtl/bdr_ram.sv */
`timescale 1ns / 1ps

module bdr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 63,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // single write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/bdr_class.sv */
`timescale 1ns / 1ps

module bdr_class (
    input  logic [bdr_pkg::CHAR_W-1:0] i_char,
    output bdr_pkg::t_cls              o_cls
);

    logic latin;
    logic cyrillic;
    logic space;

    // fixed code ranges; the ranges are disjoint, so test order is moot
    always_comb begin
        latin    = ((i_char >= 16'h0041) && (i_char <= 16'h005A)) ||
                   ((i_char >= 16'h0061) && (i_char <= 16'h007A));
        cyrillic = (i_char >= 16'h0400) && (i_char <= 16'h04FF);
        space    = (i_char == 16'h0020) || (i_char == 16'h0009) ||
                   (i_char == 16'h000A) || (i_char == 16'h000D);
        o_cls.ends_run  = latin || cyrillic || space;
        // Hebrew 0590-05FF and Arabic 0600-06FF (Arabic-Indic digits included)
        o_cls.opens_run = (i_char >= 16'h0590) && (i_char <= 16'h06FF);
    end

endmodule

/* rtl/bidi_run_reorder.sv */
`timescale 1ns / 1ps

// Right-to-left run reversal for one line of 16-bit characters. With base_rtl
// clear every word is copied through. With base_rtl set, a Hebrew or Arabic
// letter opens a run that is pushed onto a 63-entry stack RAM; a Latin or
// Cyrillic letter, whitespace or the end-of-line flag flushes it, popped in
// reverse with brackets mirrored, ahead of the closing character. Each popped
// character is read from the RAM in S_POP_RD and then loaded into the output
// register in S_POP_DAT; a closing character that follows a flush is loaded
// from S_EMIT. Characters past a full stack are dropped and run_overflow is
// set on every word of that flush. The user must write the config bit only
// while the block is idle; the block itself does not enforce it.
module bidi_run_reorder (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_wdata,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [bdr_pkg::CHAR_W-1:0]    i_char_in,
    input  logic                          i_end_of_line,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [bdr_pkg::CHAR_W-1:0]    o_char_out,
    output logic                          o_last_of_burst,
    output logic                          o_run_overflow
);

    typedef enum logic [3:0] {
        S_IDLE    = 4'b0001,
        S_POP_RD  = 4'b0010,
        S_POP_DAT = 4'b0100,
        S_EMIT    = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   r_base_rtl;
    logic   r_in_run, n_in_run;
    logic   r_ovf, n_ovf;
    logic   r_pend, n_pend;
    logic [bdr_pkg::CNT_W-1:0] r_count, n_count;
    logic [bdr_pkg::CNT_W-1:0] cnt_dec;
    logic   r_out_valid, n_out_valid;

    logic [bdr_pkg::CHAR_W-1:0] r_char;
    logic [bdr_pkg::CHAR_W-1:0] r_out_char;
    logic   r_out_last;
    logic   r_out_ovf;

    bdr_pkg::t_cls cls;
    logic   slot_free;
    logic   in_acc;
    logic   pre_flush;
    logic   emit_now;
    logic   do_push;
    logic   post_flush;
    logic   not_full;

    logic   ld_out;
    logic [bdr_pkg::CHAR_W-1:0] ld_char;
    logic   ld_last;
    logic   ld_ovf;

    logic   ram_we;
    logic   ram_re;
    logic [bdr_pkg::CHAR_W-1:0] ram_rdata;

    bdr_class u_class (
        .i_char (i_char_in),
        .o_cls  (cls)
    );

    // run stack
    bdr_ram #(
        .WIDTH (bdr_pkg::CHAR_W),
        .DEPTH (bdr_pkg::RUN_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[bdr_pkg::ADDR_W-1:0]),
        .i_wdata (i_char_in),
        .i_re    (ram_re),
        .i_raddr (cnt_dec[bdr_pkg::ADDR_W-1:0]),
        .o_rdata (ram_rdata)
    );

    // handshake and per-word decisions
    assign slot_free  = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && slot_free;
    assign in_acc     = i_in_valid && o_in_ready;
    assign pre_flush  = r_in_run && (!r_base_rtl || cls.ends_run);
    assign emit_now   = !r_base_rtl || (r_in_run ? cls.ends_run : !cls.opens_run);
    assign do_push    = !emit_now;
    assign post_flush = i_end_of_line && do_push;
    assign not_full   = r_count < bdr_pkg::CNT_W'(bdr_pkg::RUN_DEPTH);
    assign cnt_dec    = r_count - bdr_pkg::CNT_W'(1);

    // push happens on the accept edge; pops read only from the next cycle on
    assign ram_we = in_acc && do_push && not_full;
    assign ram_re = (r_state == S_POP_RD);

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_in_run    = r_in_run;
        n_ovf       = r_ovf;
        n_pend      = r_pend;
        n_count     = r_count;
        n_out_valid = r_out_valid && !i_out_ready;
        ld_out      = 1'b0;
        ld_char     = r_char;
        ld_last     = 1'b1;
        ld_ovf      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (pre_flush) begin
                        n_pend  = 1'b1;
                        n_state = S_POP_RD;
                    end else if (emit_now) begin
                        ld_out  = 1'b1;
                        ld_char = i_char_in;
                    end else begin
                        n_in_run = 1'b1;
                        if (not_full) begin
                            n_count = r_count + bdr_pkg::CNT_W'(1);
                        end else begin
                            n_ovf = 1'b1;
                        end
                        if (post_flush) begin
                            n_pend  = 1'b0;
                            n_state = S_POP_RD;
                        end
                    end
                end
            end
            S_POP_RD: begin
                n_count = cnt_dec;
                n_state = S_POP_DAT;
            end
            S_POP_DAT: begin
                if (slot_free) begin
                    ld_out  = 1'b1;
                    ld_char = bdr_pkg::mirror(ram_rdata);
                    ld_last = (r_count == '0) && !r_pend;
                    ld_ovf  = r_ovf;
                    if (r_count == '0) begin
                        n_ovf    = 1'b0;
                        n_in_run = 1'b0;
                        n_state  = r_pend ? S_EMIT : S_IDLE;
                    end else begin
                        n_state = S_POP_RD;
                    end
                end
            end
            S_EMIT: begin
                if (slot_free) begin
                    ld_out  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (ld_out) begin
            n_out_valid = 1'b1;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_base_rtl  <= 1'b0;
            r_in_run    <= 1'b0;
            r_ovf       <= 1'b0;
            r_pend      <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_in_run    <= n_in_run;
            r_ovf       <= n_ovf;
            r_pend      <= n_pend;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_base_rtl <= i_cfg_wdata;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_char <= i_char_in;
        end
        if (ld_out) begin
            r_out_char <= ld_char;
            r_out_last <= ld_last;
            r_out_ovf  <= ld_ovf;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_char_out      = r_out_char;
    assign o_last_of_burst = r_out_last;
    assign o_run_overflow  = r_out_ovf;

    // checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= bdr_pkg::CNT_W'(bdr_pkg::RUN_DEPTH))
        else $error("run stack count past depth");

    a_run_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_in_run == (r_count != '0)))
        else $error("open run flag disagrees with stack fill");

    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_we && ram_re))
        else $error("stack read and write in the same cycle");

    a_pop_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP_RD) |=> (r_state == S_POP_DAT))
        else $error("stack read not followed by data stage");

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps

module testbench;

    localparam int CW            = bdr_pkg::CHAR_W;
    localparam int STACK_DEPTH   = bdr_pkg::RUN_DEPTH;
    localparam int SETTLE_CYCLES = 16;
    localparam int PHASE_ITEMS   = 50;
    localparam int HOLD_CYCLES   = 400;
    localparam int MAX_REPORTS   = 10;

    // Character classes used by run control
    typedef enum {CC_LATIN, CC_ARABIC, CC_HEBREW, CC_DIGIT, CC_SPACE, CC_SEP, CC_OTHER}
        t_char_class;

    // Kinds of characters that the line generator draws from
    typedef enum {CK_RTL, CK_LATIN, CK_DIGIT, CK_SPACE, CK_SEP, CK_BRACKET, CK_NOISE}
        t_char_kind;

    // Config action ahead of a directed row
    typedef enum logic [1:0] {CFG_KEEP, CFG_LTR, CFG_RTL} t_cfg_op;

    typedef struct packed {
        logic [CW-1:0] ch;
        logic          last;
        logic          ovf;
    } t_out_word;

    typedef struct packed {
        t_cfg_op       cfg;
        logic [CW-1:0] ch;
        logic          eol;
        logic          typed;    // one pass-through word, known by inspection
        logic [CW-1:0] typed_ch;
    } t_dir_row;

    localparam logic [CW-1:0] SPACES [4]     = '{16'h0020, 16'h0009, 16'h000A, 16'h000D};
    localparam logic [CW-1:0] SEPARATORS [4] = '{16'h002C, 16'h002E, 16'h003A, 16'h003B};
    localparam logic [CW-1:0] BRACKETS [12]  = '{16'h0028, 16'h0029, 16'h003C, 16'h003E,
                                                 16'h005B, 16'h005D, 16'h007B, 16'h007D,
                                                 16'h00AB, 16'h00BB, 16'h2039, 16'h203A};

    // Traffic phases: sender idle and receiver stall percentages, base direction
    localparam int PHASE_TX [4]  = '{0, 58, 0, 29};
    localparam int PHASE_RX [4]  = '{0, 0, 58, 29};
    localparam bit PHASE_RTL [4] = '{1'b1, 1'b0, 1'b1, 1'b1};

    localparam int N_DIR = 26;
    t_dir_row dir_rows [N_DIR] = '{
        // reset state is LTR copy; field extremes
        '{CFG_KEEP, 16'h0000, 1'b0, 1'b1, 16'h0000},
        '{CFG_KEEP, 16'hFFFF, 1'b1, 1'b1, 16'hFFFF},
        '{CFG_KEEP, 16'h05D0, 1'b0, 1'b1, 16'h05D0},   // Hebrew copied in LTR
        // RTL: Latin outside a run passes
        '{CFG_RTL,  16'h0041, 1'b0, 1'b1, 16'h0041},
        // Hebrew run with bracket, digit, separator; whitespace closes
        '{CFG_KEEP, 16'h05D0, 1'b0, 1'b0, 16'h0000},
        '{CFG_KEEP, 16'h0028, 1'b0, 1'b0, 16'h0000},
        '{CFG_KEEP, 16'h0031, 1'b0, 1'b0, 16'h0000},
        '{CFG_KEEP, 16'h002C, 1'b0, 1'b0, 16'h0000},
        '{CFG_KEEP, 16'h00AB, 1'b0, 1'b0, 16'h0000},
        '{CFG_KEEP, 16'h0020, 1'b0, 1'b0, 16'h0000},
        // Arabic-Indic digit opens a run, Cyrillic closes it
        '{CFG_KEEP, 16'h0660, 1'b0, 1'b0, 16'h0000},
        '{CFG_KEEP, 16'h2039, 1'b0, 1'b0, 16'h0000},
        '{CFG_KEEP, 16'h0400, 1'b0, 1'b0, 16'h0000},
        // end of line flushes after the character is pushed
        '{CFG_KEEP, 16'h06FF, 1'b0, 1'b0, 16'h0000},
        '{CFG_KEEP, 16'h005B, 1'b1, 1'b0, 16'h0000},
        '{CFG_KEEP, 16'h0039, 1'b1, 1'b1, 16'h0039},   // end of line, nothing open
        // tab, line feed and carriage return each close a run
        '{CFG_KEEP, 16'h0590, 1'b0, 1'b0, 16'h0000},
        '{CFG_KEEP, 16'h007D, 1'b0, 1'b0, 16'h0000},
        '{CFG_KEEP, 16'h0009, 1'b0, 1'b0, 16'h0000},
        '{CFG_KEEP, 16'h05FF, 1'b0, 1'b0, 16'h0000},
        '{CFG_KEEP, 16'h000A, 1'b0, 1'b0, 16'h0000},
        '{CFG_KEEP, 16'h0600, 1'b0, 1'b0, 16'h0000},
        '{CFG_KEEP, 16'h000D, 1'b0, 1'b0, 16'h0000},
        // switch to LTR with a run open: flush, then copy
        '{CFG_KEEP, 16'h0627, 1'b0, 1'b0, 16'h0000},
        '{CFG_KEEP, 16'h005D, 1'b0, 1'b0, 16'h0000},
        '{CFG_LTR,  16'h007A, 1'b0, 1'b0, 16'h0000}
    };

    logic          i_clk;
    logic          i_rst_n;
    logic          i_cfg_we;
    logic          i_cfg_wdata;
    logic          i_in_valid;
    logic          o_in_ready;
    logic [CW-1:0] i_char_in;
    logic          i_end_of_line;
    logic          o_out_valid;
    logic          i_out_ready;
    logic [CW-1:0] o_char_out;
    logic          o_last_of_burst;
    logic          o_run_overflow;

    // Predictor state
    logic [CW-1:0] run_mem [STACK_DEPTH];
    int            run_cnt;
    bit            run_open;
    bit            run_ovf;
    bit            mode_rtl;
    t_out_word     burst_q [$];
    t_out_word     exp_words [$];

    // Traffic control and bookkeeping
    int tx_idle_pct;
    int rx_stall_pct;
    int rx_hold_left;
    int fail_cnt;
    int n_sent;
    int n_checked;
    int n_ovf_words;

    bidi_run_reorder i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_char_in       (i_char_in),
        .i_end_of_line   (i_end_of_line),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_char_out      (o_char_out),
        .o_last_of_burst (o_last_of_burst),
        .o_run_overflow  (o_run_overflow)
    );

    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Ranges do not overlap; Arabic-Indic digits fall in the Arabic range
    function automatic t_char_class classify_char(input logic [CW-1:0] c);
        if ((c >= 16'h0041 && c <= 16'h005A) || (c >= 16'h0061 && c <= 16'h007A))
            return CC_LATIN;
        if (c >= 16'h0600 && c <= 16'h06FF) return CC_ARABIC;
        if (c >= 16'h0590 && c <= 16'h05FF) return CC_HEBREW;
        if (c >= 16'h0030 && c <= 16'h0039) return CC_DIGIT;
        if (c == 16'h0020 || c == 16'h0009 || c == 16'h000A || c == 16'h000D)
            return CC_SPACE;
        if (c == 16'h002C || c == 16'h002E || c == 16'h003A || c == 16'h003B)
            return CC_SEP;
        if (c >= 16'h0400 && c <= 16'h04FF) return CC_LATIN;   // Cyrillic is strong LTR
        return CC_OTHER;
    endfunction

    function automatic logic [CW-1:0] mirror_bracket(input logic [CW-1:0] c);
        case (c)
            16'h0028: return 16'h0029;
            16'h0029: return 16'h0028;
            16'h003C: return 16'h003E;
            16'h003E: return 16'h003C;
            16'h005B: return 16'h005D;
            16'h005D: return 16'h005B;
            16'h007B: return 16'h007D;
            16'h007D: return 16'h007B;
            16'h00AB: return 16'h00BB;
            16'h00BB: return 16'h00AB;
            16'h2039: return 16'h203A;
            16'h203A: return 16'h2039;
            default:  return c;
        endcase
    endfunction

    // Pop the run in reverse, brackets mirrored, sticky overflow on every word
    task automatic flush_open_run();
        while (run_cnt > 0) begin
            run_cnt--;
            burst_q.push_back(t_out_word'{mirror_bracket(run_mem[run_cnt]), 1'b0, run_ovf});
        end
        run_open = 1'b0;
        run_ovf  = 1'b0;
    endtask

    task automatic stack_run_char(input logic [CW-1:0] c);
        if (run_cnt < STACK_DEPTH) begin
            run_mem[run_cnt] = c;
            run_cnt++;
        end else begin
            run_ovf = 1'b1;
        end
    endtask

    // Expected words caused by one accepted character, left in burst_q
    task automatic reorder_step(input logic [CW-1:0] c, input logic eol);
        t_char_class cls;
        burst_q.delete();
        cls = classify_char(c);
        if (!mode_rtl) begin
            if (run_open) flush_open_run();
            burst_q.push_back(t_out_word'{c, 1'b0, 1'b0});
        end else if (run_open) begin
            if (cls == CC_LATIN || cls == CC_SPACE) begin
                flush_open_run();
                burst_q.push_back(t_out_word'{c, 1'b0, 1'b0});
            end else begin
                stack_run_char(c);
            end
        end else if (cls == CC_HEBREW || cls == CC_ARABIC) begin
            run_open = 1'b1;
            stack_run_char(c);
        end else begin
            burst_q.push_back(t_out_word'{c, 1'b0, 1'b0});
        end
        if (eol && run_open) flush_open_run();
        if (burst_q.size() > 0) burst_q[burst_q.size() - 1].last = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic logic [CW-1:0] pick_char(input t_char_kind kind);
        logic [CW-1:0] c;
        case (kind)
            CK_RTL: begin
                if ($urandom_range(1) == 0) c = 16'($urandom_range(16'h05FF, 16'h0590));
                else                        c = 16'($urandom_range(16'h06FF, 16'h0600));
            end
            CK_LATIN: begin
                case ($urandom_range(2))
                    0:       c = 16'($urandom_range(16'h005A, 16'h0041));
                    1:       c = 16'($urandom_range(16'h007A, 16'h0061));
                    default: c = 16'($urandom_range(16'h04FF, 16'h0400));
                endcase
            end
            CK_DIGIT:   c = 16'($urandom_range(16'h0039, 16'h0030));
            CK_SPACE:   c = SPACES[$urandom_range(3)];
            CK_SEP:     c = SEPARATORS[$urandom_range(3)];
            CK_BRACKET: c = BRACKETS[$urandom_range(11)];
            default:    c = 16'($urandom);
        endcase
        return c;
    endfunction

    // Offer one word, wait for acceptance, then queue what it should cause
    task automatic send_word(input logic [CW-1:0] c, input logic eol,
                             input logic typed, input logic [CW-1:0] typed_ch);
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_char_in     <= c;
        i_end_of_line <= eol;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        n_sent++;
        reorder_step(c, eol);
        if (typed) exp_words.push_back(t_out_word'{typed_ch, 1'b1, 1'b0});
        else foreach (burst_q[i]) exp_words.push_back(burst_q[i]);
    endtask

    // A line of RTL runs, Latin words, numbers and noise; last word carries EOL
    task automatic send_line(input int long_pct);
        logic [CW-1:0] line_q [$];
        int            n_parts;
        int            len;
        int            pick;
        n_parts = $urandom_range(5, 1);
        for (int w = 0; w < n_parts; w++) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
                len = ($urandom_range(99) < long_pct) ? $urandom_range(75, 60)
                                                      : $urandom_range(7, 1);
                line_q.push_back(pick_char(CK_RTL));
                for (int k = 1; k < len; k++) begin
                    pick = $urandom_range(99);
                    if (pick < 35)      line_q.push_back(pick_char(CK_RTL));
                    else if (pick < 55) line_q.push_back(pick_char(CK_DIGIT));
                    else if (pick < 65) line_q.push_back(pick_char(CK_SEP));
                    else if (pick < 85) line_q.push_back(pick_char(CK_BRACKET));
                    else                line_q.push_back(pick_char(CK_NOISE));
                end
            end else if (pick < 75) begin
                repeat ($urandom_range(4, 1)) line_q.push_back(pick_char(CK_LATIN));
            end else if (pick < 85) begin
                repeat ($urandom_range(3, 1)) line_q.push_back(pick_char(CK_DIGIT));
            end else begin
                repeat ($urandom_range(2, 1)) line_q.push_back(pick_char(CK_NOISE));
            end
            if ($urandom_range(99) < 80) line_q.push_back(pick_char(CK_SPACE));
        end
        foreach (line_q[i])
            send_word(line_q[i], (i == line_q.size() - 1), 1'b0, 16'h0000);
    endtask

    // Let every expected word drain, then give trailing pushes time to land
    task automatic drain_and_settle();
        i_in_valid <= 1'b0;
        while (exp_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic rtl);
        drain_and_settle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= rtl;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        mode_rtl     = rtl;
    endtask

    function automatic void note_failure(input string msg);
        fail_cnt++;
        if (fail_cnt <= MAX_REPORTS) $display("ERROR at %0t: %s", $time, msg);
    endfunction

    // ------------------------------------------------------------------
    // Receiver: random stalls plus an optional long hold
    // ------------------------------------------------------------------
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_left > 0) begin
                i_out_ready  <= 1'b0;
                rx_hold_left--;
            end else begin
                i_out_ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // Output checker: each accepted word against the oldest expectation
    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready === 1'b1) begin
            if (exp_words.size() == 0) begin
                note_failure($sformatf("unexpected word %h last %b ovf %b",
                                       o_char_out, o_last_of_burst, o_run_overflow));
            end else begin
                want = exp_words.pop_front();
                if (o_char_out !== want.ch || o_last_of_burst !== want.last ||
                    o_run_overflow !== want.ovf)
                    note_failure($sformatf(
                        "word %0d: char %h/%h last %b/%b ovf %b/%b (expected/actual)",
                        n_checked, want.ch, o_char_out, want.last, o_last_of_burst,
                        want.ovf, o_run_overflow));
                n_checked++;
                if (o_run_overflow === 1'b1) n_ovf_words++;
            end
        end
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int phase_start;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = 1'b0;
        i_in_valid    = 1'b0;
        i_char_in     = '0;
        i_end_of_line = 1'b0;
        tx_idle_pct   = 0;
        rx_stall_pct  = 0;
        rx_hold_left  = 0;
        fail_cnt      = 0;
        n_sent        = 0;
        n_checked     = 0;
        n_ovf_words   = 0;
        run_cnt       = 0;
        run_open      = 1'b0;
        run_ovf       = 1'b0;
        mode_rtl      = 1'b0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        for (int i = 0; i < N_DIR; i++) begin
            if (dir_rows[i].cfg != CFG_KEEP) write_mode(dir_rows[i].cfg == CFG_RTL);
            send_word(dir_rows[i].ch, dir_rows[i].eol, dir_rows[i].typed,
                      dir_rows[i].typed_ch);
        end

        // random lines under each traffic pattern
        for (int p = 0; p < 4; p++) begin
            write_mode(PHASE_RTL[p]);
            tx_idle_pct  = PHASE_TX[p];
            rx_stall_pct = PHASE_RX[p];
            phase_start  = n_sent;
            while (n_sent - phase_start < PHASE_ITEMS) send_line(3);
        end

        // long receiver hold: an overflowing run backs up output and stalls input
        write_mode(1'b1);
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        rx_hold_left = HOLD_CYCLES;
        send_word(pick_char(CK_RTL), 1'b0, 1'b0, 16'h0000);
        repeat (69) send_word(pick_char(CK_RTL), 1'b0, 1'b0, 16'h0000);
        send_word(16'h0020, 1'b0, 1'b0, 16'h0000);
        repeat (4) send_line(0);

        // sender waits for everything to drain, then resumes under mixed traffic
        drain_and_settle();
        tx_idle_pct  = 29;
        rx_stall_pct = 29;
        repeat (3) send_line(5);

        drain_and_settle();
        if (exp_words.size() != 0)
            note_failure($sformatf("%0d expected words never arrived", exp_words.size()));

        $display("Run covered %0d characters in LTR and RTL modes; %0d words checked, %0d %s",
                 n_sent, n_checked, n_ovf_words, "with the run overflow flag.");
        $display("Traffic: free flow, sender gaps, receiver stalls, mixed, and a long hold.");
        if (fail_cnt == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
